@@ design/rsi_pkg.sv @@
// Shared types, widths and helpers for the ray/sphere intersection pipeline.
package rsi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int DIR_W     = FRAC_BITS + 2;
	localparam int RAD_W     = COORD_W - 1;
	localparam int D_W       = COORD_W + 1;
	localparam int PU_W      = D_W + DIR_W;
	localparam int SU_W      = PU_W + 2;
	localparam int B_W       = SU_W - FRAC_BITS;
	localparam int DQ_W      = 2 * D_W;
	localparam int DD_W      = DQ_W + 2;
	localparam int RR_W      = 2 * RAD_W;
	localparam int E_W       = DD_W + 1;
	localparam int HALF      = B_W / 2;
	localparam int BH_W      = B_W - HALF;
	localparam int DISC_W    = 2 * B_W + 2;
	localparam int X_W       = 2 * B_W;
	localparam int ROOT_W    = B_W;
	localparam int REM_W     = ROOT_W + 3;
	localparam int LAM_W     = B_W + 2;
	localparam int PROD_W    = LAM_W + DIR_W;
	localparam int V_W       = PROD_W - FRAC_BITS + 1;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		HIT_NONE    = 2'd0,
		HIT_TANGENT = 2'd1,
		HIT_TWO     = 2'd2
	} hit_kind_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ox;
		logic signed [COORD_W-1:0] oy;
		logic signed [COORD_W-1:0] oz;
		logic signed [DIR_W-1:0]   ux;
		logic signed [DIR_W-1:0]   uy;
		logic signed [DIR_W-1:0]   uz;
		logic signed [B_W-1:0]     b;
		hit_kind_t                 kind;
	} ray_t;

	typedef struct packed {
		logic [1:0]                hit_count;
		logic                      point_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      saturated;
		logic                      is_last;
	} result_t;

	// Clamp a wide coordinate to the signed coordinate range; the top bit flags a clamp.
	function automatic logic [COORD_W:0] clamp_coord(input logic signed [V_W-1:0] v);
		logic fits;
		fits = (v[V_W-1:COORD_W-1] == '0) || (v[V_W-1:COORD_W-1] == '1);
		if (fits) begin
			return {1'b0, v[COORD_W-1:0]};
		end else if (v[V_W-1]) begin
			return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

@@ design/rsi_if.sv @@
// Ray input and hit result channel interfaces.
interface rsi_ray_if;
	import rsi_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] origin_x;
	logic signed [COORD_W-1:0] origin_y;
	logic signed [COORD_W-1:0] origin_z;
	logic signed [DIR_W-1:0]   dir_x;
	logic signed [DIR_W-1:0]   dir_y;
	logic signed [DIR_W-1:0]   dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rsi_hit_if;
	import rsi_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                hit_count;
	logic                      point_index;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic                      saturated;
	logic                      is_last;

	modport source (output valid, hit_count, point_index, point_x, point_y, point_z,
		saturated, is_last, input ready);
	modport sink (input valid, hit_count, point_index, point_x, point_y, point_z,
		saturated, is_last, output ready);
endinterface

@@ design/ray_sphere_intersect.sv @@
// Top level of the fixed-point ray/sphere intersection pipeline.
//
//   Channel  Direction  Transfer unit        Fields
//   ray      in         one ray              origin_x/y/z, dir_x/y/z
//   hit      out        one result item      hit_count, point_index, point_x/y/z,
//                                            saturated, is_last
//   cfg      in         one register write   cfg_we, cfg_index, cfg_data
//
// A ray can be accepted every cycle while the pipeline advances; a ray with
// two hits gives two result items, and while the second waits in the pending
// slot the last stage cannot drain. A ray passes through five stages of
// arithmetic, 37 square-root stages (one root bit each), three stages of
// point arithmetic and the output register. The whole pipeline advances as one
// when its last stage is empty or can be handed to the output side, so a
// stall freezes every stage in place. Reset clears valid bits and sets the
// radius to 1.0 and the center to the origin.
module ray_sphere_intersect (
	input  logic                       clk,
	input  logic                       arst_n,
	rsi_ray_if.sink                    ray,
	rsi_hit_if.source                  hit,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [rsi_pkg::COORD_W-1:0] cfg_data
);
	import rsi_pkg::*;

	// Configuration registers.
	logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [RAD_W-1:0]          rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
			rad_q <= RAD_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: cx_q  <= cfg_data;
				REG_CENTER_Y: cy_q  <= cfg_data;
				REG_CENTER_Z: cz_q  <= cfg_data;
				REG_RADIUS:   rad_q <= cfg_data[RAD_W-1:0];
				default:      ;
			endcase
		end
	end

	// Global advance: every stage moves together when the last one can drain.
	logic adv;
	logic take;
	logic vld_s8;
	logic out_vld_q, pend_vld_q;
	logic out_free;

	assign out_free  = !out_vld_q || hit.ready;
	assign take      = vld_s8 && !pend_vld_q && out_free;
	assign adv       = !vld_s8 || take;
	assign ray.ready = adv;

	// Stage 1: offset from the sphere center.
	logic                      vld_s1;
	logic signed [COORD_W-1:0] ox_s1, oy_s1, oz_s1;
	logic signed [DIR_W-1:0]   ux_s1, uy_s1, uz_s1;
	logic signed [D_W-1:0]     dx_s1, dy_s1, dz_s1;
	logic [RAD_W-1:0]          r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= ray.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_s1 <= ray.origin_x;
			oy_s1 <= ray.origin_y;
			oz_s1 <= ray.origin_z;
			ux_s1 <= ray.dir_x;
			uy_s1 <= ray.dir_y;
			uz_s1 <= ray.dir_z;
			dx_s1 <= D_W'(ray.origin_x) - D_W'(cx_q);
			dy_s1 <= D_W'(ray.origin_y) - D_W'(cy_q);
			dz_s1 <= D_W'(ray.origin_z) - D_W'(cz_q);
			r_s1  <= rad_q;
		end
	end

	// Stage 2: the products d.u, d.d and r.r.
	logic                      vld_s2;
	logic signed [COORD_W-1:0] ox_s2, oy_s2, oz_s2;
	logic signed [DIR_W-1:0]   ux_s2, uy_s2, uz_s2;
	logic signed [PU_W-1:0]    px_s2, py_s2, pz_s2;
	logic signed [DQ_W-1:0]    qx_s2, qy_s2, qz_s2;
	logic [RR_W-1:0]           rr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_s2 <= ox_s1;
			oy_s2 <= oy_s1;
			oz_s2 <= oz_s1;
			ux_s2 <= ux_s1;
			uy_s2 <= uy_s1;
			uz_s2 <= uz_s1;
			px_s2 <= PU_W'(dx_s1) * PU_W'(ux_s1);
			py_s2 <= PU_W'(dy_s1) * PU_W'(uy_s1);
			pz_s2 <= PU_W'(dz_s1) * PU_W'(uz_s1);
			qx_s2 <= DQ_W'(dx_s1) * DQ_W'(dx_s1);
			qy_s2 <= DQ_W'(dy_s1) * DQ_W'(dy_s1);
			qz_s2 <= DQ_W'(dz_s1) * DQ_W'(dz_s1);
			rr_s2 <= RR_W'(r_s1) * RR_W'(r_s1);
		end
	end

	// Stage 3: b = floor(d.u) at the coordinate scale, and the sum of squares.
	logic signed [SU_W-1:0]    bsum;
	logic                      vld_s3;
	logic signed [COORD_W-1:0] ox_s3, oy_s3, oz_s3;
	logic signed [DIR_W-1:0]   ux_s3, uy_s3, uz_s3;
	logic signed [B_W-1:0]     b_s3;
	logic signed [DD_W-1:0]    dd_s3;
	logic [RR_W-1:0]           rr_s3;

	assign bsum = SU_W'(px_s2) + SU_W'(py_s2) + SU_W'(pz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_s3 <= ox_s2;
			oy_s3 <= oy_s2;
			oz_s3 <= oz_s2;
			ux_s3 <= ux_s2;
			uy_s3 <= uy_s2;
			uz_s3 <= uz_s2;
			b_s3  <= B_W'(bsum >>> FRAC_BITS);
			dd_s3 <= DD_W'(qx_s2) + DD_W'(qy_s2) + DD_W'(qz_s2);
			rr_s3 <= rr_s2;
		end
	end

	// Stage 4: b squared as three partial products, and r.r - d.d.
	logic [B_W-1:0]            mb;
	logic [BH_W-1:0]           bh;
	logic [HALF-1:0]           bl;
	logic                      vld_s4;
	logic signed [COORD_W-1:0] ox_s4, oy_s4, oz_s4;
	logic signed [DIR_W-1:0]   ux_s4, uy_s4, uz_s4;
	logic signed [B_W-1:0]     b_s4;
	logic [2*BH_W-1:0]         hh_s4;
	logic [BH_W+HALF-1:0]      hl_s4;
	logic [2*HALF-1:0]         ll_s4;
	logic signed [E_W-1:0]     e_s4;

	assign mb = b_s3[B_W-1] ? B_W'(-b_s3) : B_W'(b_s3);
	assign bh = mb[B_W-1:HALF];
	assign bl = mb[HALF-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_s4 <= ox_s3;
			oy_s4 <= oy_s3;
			oz_s4 <= oz_s3;
			ux_s4 <= ux_s3;
			uy_s4 <= uy_s3;
			uz_s4 <= uz_s3;
			b_s4  <= b_s3;
			hh_s4 <= (2*BH_W)'(bh) * (2*BH_W)'(bh);
			hl_s4 <= (BH_W+HALF)'(bh) * (BH_W+HALF)'(bl);
			ll_s4 <= (2*HALF)'(bl) * (2*HALF)'(bl);
			e_s4  <= $signed(E_W'(rr_s3)) - E_W'(dd_s3);
		end
	end

	// Stage 5: discriminant and case selection.
	logic [DISC_W-1:0] disc;
	logic              disc_neg, disc_zero;
	logic              vld_s5;
	logic [X_W-1:0]    x_s5;
	ray_t              ray_s5;

	assign disc = (DISC_W'(hh_s4) << (2*HALF)) + (DISC_W'(hl_s4) << (HALF+1))
		+ DISC_W'(ll_s4) + DISC_W'(e_s4);
	assign disc_neg  = disc[DISC_W-1];
	assign disc_zero = (disc == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s5      <= disc_neg ? '0 : disc[X_W-1:0];
			ray_s5.ox <= ox_s4;
			ray_s5.oy <= oy_s4;
			ray_s5.oz <= oz_s4;
			ray_s5.ux <= ux_s4;
			ray_s5.uy <= uy_s4;
			ray_s5.uz <= uz_s4;
			ray_s5.b  <= b_s4;
			priority if (disc_neg) begin
				ray_s5.kind <= HIT_NONE;
			end else if (disc_zero) begin
				ray_s5.kind <= HIT_TANGENT;
			end else begin
				ray_s5.kind <= HIT_TWO;
			end
		end
	end

	// Square root of the discriminant.
	logic              vld_sq;
	logic [ROOT_W-1:0] root_sq;
	ray_t              ray_sq;

	rsi_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s5),
		.x_in     (x_s5),
		.ray_in   (ray_s5),
		.vld_out  (vld_sq),
		.root_out (root_sq),
		.ray_out  (ray_sq)
	);

	// Stage 6: the two distances along the ray, -b + s and -b - s.
	logic                    vld_s6;
	ray_t                    ray_s6;
	logic signed [LAM_W-1:0] lp_s6, lm_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s6 <= ray_sq;
			lp_s6  <= LAM_W'(root_sq) - LAM_W'(ray_sq.b);
			lm_s6  <= -LAM_W'(ray_sq.b) - LAM_W'(root_sq);
		end
	end

	// Stage 7: distance times direction for both points.
	logic                     vld_s7;
	ray_t                     ray_s7;
	logic signed [PROD_W-1:0] mpx_s7, mpy_s7, mpz_s7;
	logic signed [PROD_W-1:0] mmx_s7, mmy_s7, mmz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s7 <= ray_s6;
			mpx_s7 <= PROD_W'(lp_s6) * PROD_W'(ray_s6.ux);
			mpy_s7 <= PROD_W'(lp_s6) * PROD_W'(ray_s6.uy);
			mpz_s7 <= PROD_W'(lp_s6) * PROD_W'(ray_s6.uz);
			mmx_s7 <= PROD_W'(lm_s6) * PROD_W'(ray_s6.ux);
			mmy_s7 <= PROD_W'(lm_s6) * PROD_W'(ray_s6.uy);
			mmz_s7 <= PROD_W'(lm_s6) * PROD_W'(ray_s6.uz);
		end
	end

	// Stage 8: add to the origin and clamp; both result items are formed here.
	logic [COORD_W:0] cpx, cpy, cpz, cmx, cmy, cmz;
	result_t          first_s8, second_s8;

	assign cpx = clamp_coord(V_W'(ray_s7.ox) + V_W'(mpx_s7 >>> FRAC_BITS));
	assign cpy = clamp_coord(V_W'(ray_s7.oy) + V_W'(mpy_s7 >>> FRAC_BITS));
	assign cpz = clamp_coord(V_W'(ray_s7.oz) + V_W'(mpz_s7 >>> FRAC_BITS));
	assign cmx = clamp_coord(V_W'(ray_s7.ox) + V_W'(mmx_s7 >>> FRAC_BITS));
	assign cmy = clamp_coord(V_W'(ray_s7.oy) + V_W'(mmy_s7 >>> FRAC_BITS));
	assign cmz = clamp_coord(V_W'(ray_s7.oz) + V_W'(mmz_s7 >>> FRAC_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			second_s8.hit_count   <= 2'd2;
			second_s8.point_index <= 1'b1;
			second_s8.point_x     <= cmx[COORD_W-1:0];
			second_s8.point_y     <= cmy[COORD_W-1:0];
			second_s8.point_z     <= cmz[COORD_W-1:0];
			second_s8.saturated   <= cmx[COORD_W] | cmy[COORD_W] | cmz[COORD_W];
			second_s8.is_last     <= 1'b1;
			first_s8.point_index  <= 1'b0;
			unique case (ray_s7.kind)
				HIT_NONE: begin
					first_s8.hit_count <= 2'd0;
					first_s8.point_x   <= '0;
					first_s8.point_y   <= '0;
					first_s8.point_z   <= '0;
					first_s8.saturated <= 1'b0;
					first_s8.is_last   <= 1'b1;
				end
				HIT_TANGENT, HIT_TWO: begin
					first_s8.hit_count <= (ray_s7.kind == HIT_TWO) ? 2'd2 : 2'd1;
					first_s8.point_x   <= cpx[COORD_W-1:0];
					first_s8.point_y   <= cpy[COORD_W-1:0];
					first_s8.point_z   <= cpz[COORD_W-1:0];
					first_s8.saturated <= cpx[COORD_W] | cpy[COORD_W] | cpz[COORD_W];
					first_s8.is_last   <= (ray_s7.kind != HIT_TWO);
				end
				default: begin
					first_s8.hit_count <= 2'd0;
					first_s8.point_x   <= '0;
					first_s8.point_y   <= '0;
					first_s8.point_z   <= '0;
					first_s8.saturated <= 1'b0;
					first_s8.is_last   <= 1'b1;
				end
			endcase
		end
	end

	// Output register plus a pending slot for the second point of a two-hit ray.
	result_t out_q, pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (out_free) begin
			if (pend_vld_q) begin
				out_vld_q  <= 1'b1;
				pend_vld_q <= 1'b0;
			end else begin
				out_vld_q  <= vld_s8;
				pend_vld_q <= vld_s8 && !first_s8.is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_vld_q) begin
				out_q <= pend_q;
			end else if (vld_s8) begin
				out_q  <= first_s8;
				pend_q <= second_s8;
			end
		end
	end

	assign hit.valid       = out_vld_q;
	assign hit.hit_count   = out_q.hit_count;
	assign hit.point_index = out_q.point_index;
	assign hit.point_x     = out_q.point_x;
	assign hit.point_y     = out_q.point_y;
	assign hit.point_z     = out_q.point_z;
	assign hit.saturated   = out_q.saturated;
	assign hit.is_last     = out_q.is_last;

`ifndef SYNTHESIS
	// The second point never waits without the first one in the output register.
	a_pend_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> out_vld_q)
		else $error("pending second point without a result in the output register");

	// A result that is not the last of its ray is always followed by another.
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_q.is_last) |=> out_vld_q)
		else $error("first point of a two-hit ray not followed by its second");

	// A miss carries a zero point and no clamp flag.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.hit_count == 2'd0) |->
		(out_q.point_x == '0 && out_q.point_y == '0 && out_q.point_z == '0
		&& !out_q.saturated && out_q.is_last))
		else $error("miss result with a nonzero point");

	// The pipeline only takes a new ray from the last stage while no second point waits.
	a_take_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !pend_vld_q)
		else $error("ray taken from the last stage while a second point waits");
`endif

endmodule

@@ design/rsi_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with ray payload alongside.
module rsi_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      vld_in,
	input  logic [rsi_pkg::X_W-1:0]   x_in,
	input  rsi_pkg::ray_t             ray_in,
	output logic                      vld_out,
	output logic [rsi_pkg::ROOT_W-1:0] root_out,
	output rsi_pkg::ray_t             ray_out
);
	import rsi_pkg::*;

	logic              vld_s  [0:ROOT_W];
	logic [X_W-1:0]    x_s    [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	ray_t              ray_s  [0:ROOT_W];

	always_comb begin
		vld_s[0]  = vld_in;
		x_s[0]    = x_in;
		rem_s[0]  = '0;
		root_s[0] = '0;
		ray_s[0]  = ray_in;
	end

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		always_comb begin
			rem_sh = {rem_s[i][REM_W-3:0], x_s[i][X_W-1:X_W-2]};
			trial  = REM_W'({root_s[i], 2'b01});
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1]  <= ge ? rem_sh - trial : rem_sh;
				root_s[i+1] <= {root_s[i][ROOT_W-2:0], ge};
				x_s[i+1]    <= {x_s[i][X_W-3:0], 2'b00};
				ray_s[i+1]  <= ray_s[i];
			end
		end
	end

	assign vld_out  = vld_s[ROOT_W];
	assign root_out = root_s[ROOT_W];
	assign ray_out  = ray_s[ROOT_W];

endmodule

@@ bench/ray_sphere_intersect_checker.sv @@
// Checker for the ray/sphere intersection block: predicts hit results and compares them.
module ray_sphere_intersect_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	rsi_ray_if                          ray,
	rsi_hit_if                          hit,
	input  logic                        cfg_we,
	input  rsi_pkg::cfg_reg_t           cfg_index,
	input  logic [rsi_pkg::COORD_W-1:0] cfg_data,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rsi_pkg::*;

	logic signed [COORD_W-1:0] sph_cx, sph_cy, sph_cz;
	logic [RAD_W-1:0]          sph_rad;
	result_t                   hits_due[$];

	// Clamp one coordinate of origin + lambda*u to the signed coordinate range.
	function automatic logic signed [COORD_W-1:0] place_coord(input logic signed [127:0] o,
			input logic signed [127:0] lam, input logic signed [127:0] u, inout logic sat);
		logic signed [127:0] v;
		v = o + ((lam * u) >>> FRAC_BITS);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			v = 128'sd2147483647;
		end else if (v < -128'sd2147483648) begin
			sat = 1'b1;
			v = -128'sd2147483648;
		end
		return v[COORD_W-1:0];
	endfunction

	function automatic result_t make_point(input logic [1:0] cnt, input logic idx,
			input logic signed [127:0] o[3], input logic signed [127:0] lam,
			input logic signed [127:0] u[3], input logic last);
		result_t r;
		logic sat;
		sat = 1'b0;
		r.hit_count = cnt;
		r.point_index = idx;
		r.point_x = place_coord(o[0], lam, u[0], sat);
		r.point_y = place_coord(o[1], lam, u[1], sat);
		r.point_z = place_coord(o[2], lam, u[2], sat);
		r.saturated = sat;
		r.is_last = last;
		return r;
	endfunction

	// Work out the result items for one ray against the current sphere.
	function automatic void predict_hits(input logic signed [COORD_W-1:0] ox, oy, oz,
			input logic signed [DIR_W-1:0] ux, uy, uz);
		logic signed [127:0] o[3], u[3], d[3], ctr[3], acc, b, disc, rad, s;
		logic [127:0] root, cand;
		result_t miss;
		o[0] = ox; o[1] = oy; o[2] = oz;
		u[0] = ux; u[1] = uy; u[2] = uz;
		ctr[0] = sph_cx; ctr[1] = sph_cy; ctr[2] = sph_cz;
		rad = {97'd0, sph_rad};
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			d[i] = o[i] - ctr[i];
			acc = acc + d[i] * u[i];
		end
		b = acc >>> FRAC_BITS;
		disc = b * b + rad * rad;
		for (int i = 0; i < 3; i++)
			disc = disc - d[i] * d[i];
		if (disc < 0) begin
			miss = '0;
			miss.is_last = 1'b1;
			hits_due.push_back(miss);
		end else if (disc == 0) begin
			hits_due.push_back(make_point(HIT_TANGENT, 1'b0, o, -b, u, 1'b1));
		end else begin
			// Bitwise integer square root, one result bit at a time from the top.
			root = '0;
			for (int k = 63; k >= 0; k--) begin
				cand = root | (128'd1 << k);
				if (cand * cand <= disc)
					root = cand;
			end
			s = root;
			hits_due.push_back(make_point(HIT_TWO, 1'b0, o, -b + s, u, 1'b0));
			hits_due.push_back(make_point(HIT_TWO, 1'b1, o, -b - s, u, 1'b1));
		end
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			sph_cx <= '0;
			sph_cy <= '0;
			sph_cz <= '0;
			sph_rad <= RAD_W'(1 << FRAC_BITS);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CENTER_X: sph_cx <= cfg_data;
					REG_CENTER_Y: sph_cy <= cfg_data;
					REG_CENTER_Z: sph_cz <= cfg_data;
					REG_RADIUS:   sph_rad <= cfg_data[RAD_W-1:0];
				endcase
			end
			if (ray.valid && ray.ready)
				predict_hits(ray.origin_x, ray.origin_y, ray.origin_z,
					ray.dir_x, ray.dir_y, ray.dir_z);
			if (hit.valid && hit.ready) begin
				if (hits_due.size() == 0) begin
					$display("%0t: unexpected result transfer, point %0h %0h %0h", $time,
						hit.point_x, hit.point_y, hit.point_z);
					fail_count++;
				end else begin
					want = hits_due.pop_front();
					if (hit.hit_count !== want.hit_count)
						report("hit_count", want.hit_count, hit.hit_count);
					if (hit.point_index !== want.point_index)
						report("point_index", want.point_index, hit.point_index);
					if (hit.point_x !== want.point_x)
						report("point_x", want.point_x, hit.point_x);
					if (hit.point_y !== want.point_y)
						report("point_y", want.point_y, hit.point_y);
					if (hit.point_z !== want.point_z)
						report("point_z", want.point_z, hit.point_z);
					if (hit.saturated !== want.saturated)
						report("saturated", want.saturated, hit.saturated);
					if (hit.is_last !== want.is_last)
						report("is_last", want.is_last, hit.is_last);
				end
			end
			pending <= hits_due.size();
		end
	end
endmodule

@@ bench/ray_sphere_intersect_tb.sv @@
// Top of the ray/sphere intersection testbench: clock, reset, stimulus and verdict.
module ray_sphere_intersect_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rsi_pkg::*;

	localparam int ONE         = 1 << FRAC_BITS;
	localparam int DRAIN       = 60;      // drain margin, longer than the pipeline latency
	localparam int CYCLE_LIMIT = 600000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_reg_t             cfg_index;
	logic [COORD_W-1:0]   cfg_data;
	int                   fail_count;
	int                   pending;
	int                   cycles;
	bit                   hold_off_req;

	// Sphere as the stimulus knows it, used to aim rays at the surface.
	int                   aim_cx, aim_cy, aim_cz, aim_rad;

	rsi_ray_if ray ();
	rsi_hit_if hit ();

	ray_sphere_intersect uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray       (ray),
		.hit       (hit),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ray_sphere_intersect_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.ray        (ray),
		.hit        (hit),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Mostly short gaps, a few long ones, and plenty of back-to-back cycles.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The watchdog ends a run that has hung.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The result side drops ready at random. On request it holds off for a long
	// stretch so that the pipeline fills up and back-pressures the ray channel.
	initial begin
		int gap;
		hit.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hit.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			gap = pick_gap();
			if (gap == 0) begin
				hit.ready <= 1'b1;
				@(posedge clk);
			end else begin
				hit.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Offer one ray and hold it until the transfer happens; then maybe idle.
	task automatic send_ray(input logic [COORD_W-1:0] ox, oy, oz,
			input logic [DIR_W-1:0] ux, uy, uz);
		int gap;
		ray.valid <= 1'b1;
		ray.origin_x <= ox;
		ray.origin_y <= oy;
		ray.origin_z <= oz;
		ray.dir_x <= ux;
		ray.dir_y <= uy;
		ray.dir_z <= uz;
		do @(posedge clk); while (!ray.ready);
		gap = pick_gap();
		if (gap > 0) begin
			ray.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Let every expected result arrive, then a latency's worth of cycles more.
	task automatic drain();
		ray.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Sphere registers are only written while the pipeline is empty.
	task automatic set_sphere(input int cx, cy, cz, input int rad);
		cfg_we <= 1'b1;
		cfg_index <= REG_CENTER_X;
		cfg_data <= cx;
		@(posedge clk);
		cfg_index <= REG_CENTER_Y;
		cfg_data <= cy;
		@(posedge clk);
		cfg_index <= REG_CENTER_Z;
		cfg_data <= cz;
		@(posedge clk);
		cfg_index <= REG_RADIUS;
		cfg_data <= rad;
		@(posedge clk);
		cfg_we <= 1'b0;
		aim_cx = cx;
		aim_cy = cy;
		aim_cz = cz;
		aim_rad = rad;
	endtask

	function automatic logic [DIR_W-1:0] rand_dir();
		return DIR_W'($urandom_range(0, 2 * ONE) - ONE);
	endfunction

	// Random rays: most start near the sphere and are likely to cross it,
	// the rest are raw bit patterns over the whole field range.
	task automatic random_rays(input int count);
		int span;
		for (int n = 0; n < count; n++) begin
			span = (aim_rad > 32'h1fffffff || aim_rad < 16) ? 32'h1fffffff : 3 * aim_rad;
			if ($urandom_range(0, 99) < 75)
				send_ray(aim_cx + $urandom_range(0, 2 * span) - span,
					aim_cy + $urandom_range(0, 2 * span) - span,
					aim_cz + $urandom_range(0, 2 * span) - span,
					rand_dir(), rand_dir(), rand_dir());
			else
				send_ray($urandom, $urandom, $urandom,
					DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom));
		end
	endtask

	initial begin
		cycles = 0;
		hold_off_req = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_data = '0;
		ray.valid = 1'b0;
		ray.origin_x = '0;
		ray.origin_y = '0;
		ray.origin_z = '0;
		ray.dir_x = '0;
		ray.dir_y = '0;
		ray.dir_z = '0;
		aim_cx = 0;
		aim_cy = 0;
		aim_cz = 0;
		aim_rad = ONE;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rays against the unit sphere at the origin (reset values).
		send_ray(0, 0, -2 * ONE, 0, 0, ONE);             // two hits along z
		send_ray(ONE, 0, -2 * ONE, 0, 0, ONE);           // grazes the surface: tangent
		send_ray(3 * ONE, 0, 0, 0, ONE, 0);              // passes by: miss
		send_ray(0, 0, 0, ONE, 0, 0);                    // starts at the center
		send_ray(0, 0, 0, -ONE, 0, 0);
		send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, ONE, ONE, ONE);
		send_ray(32'h80000000, 32'h80000000, 32'h80000000, -ONE, -ONE, -ONE);
		send_ray(0, 0, 0, 18'h1ffff, 18'h20000, 18'h1ffff); // directions beyond unit
		send_ray(0, 0, 0, 18'h20000, 18'h20000, 18'h20000);
		send_ray(0, 0, 0, 0, 0, 0);                      // zero direction
		send_ray(ONE / 2, ONE / 3, -ONE / 5, 0, ONE, 0);
		drain();

		// Huge sphere near the corner of the range: points leave the range and clamp.
		set_sphere(32'h7fff0000, 32'h7fff0000, 32'h7fff0000, 32'h7fffffff);
		send_ray(32'h7fff0000, 32'h7fff0000, 32'h7fff0000, ONE, 0, 0);
		send_ray(32'h7fff0000, 32'h7fff0000, 32'h7fff0000, -ONE, -ONE, 0);
		send_ray(32'h80000000, 32'h7fffffff, 0, ONE, -ONE, ONE);
		send_ray(0, 0, 0, 0, ONE, 0);
		send_ray(32'h80000000, 32'h80000000, 32'h80000000, ONE, ONE, ONE);
		drain();

		// Radius zero: a ray through the center is tangent, everything else misses.
		set_sphere(32'h80000000, 0, 5 * ONE, 0);
		send_ray(32'h80000000, 0, 0, 0, 0, ONE);
		send_ray(32'h80000000, ONE, 0, 0, 0, ONE);
		drain();

		// Random sphere of moderate size; midway the receiver stalls for a long stretch.
		set_sphere($urandom_range(0, 64 * ONE) - 32 * ONE, $urandom_range(0, 64 * ONE) - 32 * ONE,
			$urandom_range(0, 64 * ONE) - 32 * ONE, $urandom_range(ONE / 4, 8 * ONE));
		random_rays(60);
		hold_off_req = 1'b1;
		random_rays(90);
		drain();

		// Small sphere with fine fractional coordinates.
		set_sphere($urandom_range(0, ONE), $urandom_range(0, ONE), $urandom_range(0, ONE),
			$urandom_range(1, ONE));
		random_rays(100);
		drain();

		// Centers at the range extremes and a very large radius.
		set_sphere(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		random_rays(70);
		drain();

		// Back to the reset values, then a fully random sphere.
		set_sphere(0, 0, 0, ONE);
		random_rays(60);
		drain();
		set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32'h7fffffff));
		random_rays(60);
		drain();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
